[hdl/slot_table_with_free_slot_finder_defines.svh]
// Assertion macros shared by the table logic.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SLOT_TABLE_WITH_FREE_SLOT_FINDER_DEFINES_SVH
`define SLOT_TABLE_WITH_FREE_SLOT_FINDER_DEFINES_SVH

`define STF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define STF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/stf_pkg.sv]
package stf_pkg;

  localparam int CMD_W      = 3;
  localparam int KEY_W      = 10;
  localparam int VAL_W      = 32;
  localparam int IDXO_W     = 11;
  localparam int CNTO_W     = 11;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;
  localparam int MAP_W      = 32;
  localparam int MAP_SH     = 5;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_GET        = 3'd0;
  localparam cmd_t CMD_FIND_OCC   = 3'd1;
  localparam cmd_t CMD_FIND_EMPTY = 3'd2;
  localparam cmd_t CMD_STORE      = 3'd3;
  localparam cmd_t CMD_ALLOC      = 3'd4;
  localparam cmd_t CMD_REMOVE     = 3'd5;

endpackage

[hdl/stf_ram.sv]
module stf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/stf_ctrl.sv]
`include "slot_table_with_free_slot_finder_defines.svh"

module stf_ctrl
  import stf_pkg::*;
#(
  parameter int SLOT_COUNT = 1024,
  parameter int VALUE_BITS = 32,
  parameter int IDX_W      = 10,
  parameter int RA_W       = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  vr_en,
  output logic [IDX_W-1:0]      vr_addr,
  input  logic [VALUE_BITS-1:0] vr_data,
  output logic                  vw_en,
  output logic [IDX_W-1:0]      vw_addr,
  output logic [VALUE_BITS-1:0] vw_data,
  output logic                  mr_en,
  output logic [RA_W-1:0]       mr_addr,
  input  logic [MAP_W-1:0]      mr_data,
  output logic                  mw_en,
  output logic [RA_W-1:0]       mw_addr,
  output logic [MAP_W-1:0]      mw_data
);

  localparam int ROWS  = (SLOT_COUNT + MAP_W - 1) / MAP_W;
  localparam int SW    = RA_W + MAP_SH;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROW  = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_VAL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  cmd_t                  cmd_r;
  logic [KEY_W-1:0]      key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  in_range_r;
  logic [SW-1:0]         pos_r;
  logic [ROWS-1:0]       row_any_r, row_full_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] res_value_r;
  logic [IDXO_W-1:0]     res_index_r;
  logic                  res_status_r;
  logic                  out_valid_r;
  logic [VAL_W-1:0]      out_value_r;
  logic [IDXO_W-1:0]     out_index_r;
  logic                  out_status_r;
  logic [CNTO_W-1:0]     out_count_r;

  logic                  in_fire, out_load, skip, want, scan_cmd;
  logic [KEY_W-1:0]      in_key;
  logic [VAL_W-1:0]      in_value;
  logic [RA_W-1:0]       row_c, nrow;
  logic [MAP_SH-1:0]     off_c, ff, wr_off;
  logic [MAP_W-1:0]      mrow, cand, nr;
  logic [ROWS-1:0]       rcand;
  logic                  hit, hit_ok, rhit;
  logic [SW-1:0]         found_pos;
  logic [VALUE_BITS-1:0] new_val, old_val;
  logic                  was_occ, now_occ, do_write;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_key    = in_tdata[KEY_W-1:0];
  assign in_value  = in_tdata[KEY_W+VAL_W-1:KEY_W];

  assign row_c    = pos_r[SW-1:MAP_SH];
  assign off_c    = pos_r[MAP_SH-1:0];
  assign mrow     = row_any_r[row_c] ? mr_data : '0;
  assign want     = (cmd_r == CMD_FIND_OCC);
  assign scan_cmd = (cmd_r == CMD_FIND_OCC) || (cmd_r == CMD_FIND_EMPTY) ||
                    (cmd_r == CMD_ALLOC);
  assign cand     = want ? mrow : ~mrow;
  assign rcand    = want ? row_any_r : ~row_full_r;
  assign skip     = (cmd_r > CMD_REMOVE) || (!in_range_r && cmd_r != CMD_ALLOC);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    hit = 1'b0;
    ff  = '0;
    for (int b = MAP_W - 1; b >= 0; b--) begin
      if (cand[b] && (MAP_SH'(b) >= off_c)) begin
        hit = 1'b1;
        ff  = MAP_SH'(b);
      end
    end
  end

  always_comb begin
    rhit = 1'b0;
    nrow = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (rcand[r] && (RA_W'(r) > row_c)) begin
        rhit = 1'b1;
        nrow = RA_W'(r);
      end
    end
  end

  assign found_pos = {row_c, ff};
  assign hit_ok    = hit && (32'(found_pos) < 32'(SLOT_COUNT));

  assign wr_off   = (cmd_r == CMD_ALLOC) ? ff : off_c;
  assign new_val  = (cmd_r == CMD_REMOVE) ? '0 : val_r;
  assign now_occ  = |new_val;
  assign was_occ  = mrow[wr_off];
  assign old_val  = was_occ ? vr_data : '0;
  assign do_write = (state_r == S_EVAL) &&
                    ((cmd_r == CMD_STORE) || (cmd_r == CMD_REMOVE) ||
                     ((cmd_r == CMD_ALLOC) && hit_ok));

  always_comb begin
    nr         = mrow;
    nr[wr_off] = now_occ;
  end

  assign vr_en   = (state_r == S_ROW) || ((state_r == S_EVAL) && want && hit_ok);
  assign vr_addr = (state_r == S_ROW) ? IDX_W'(pos_r) : IDX_W'(found_pos);
  assign vw_en   = do_write;
  assign vw_addr = IDX_W'({row_c, wr_off});
  assign vw_data = new_val;
  assign mr_en   = (state_r == S_ROW);
  assign mr_addr = row_c;
  assign mw_en   = do_write;
  assign mw_addr = row_c;
  assign mw_data = nr;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_write && was_occ && !now_occ) begin
      cnt_nxt = cnt_r - 1'b1;
    end else if (do_write && !was_occ && now_occ) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        state_nxt = skip ? S_OUT : S_EVAL;
      end
      S_EVAL: begin
        if (scan_cmd && hit_ok) begin
          state_nxt = want ? S_VAL : S_OUT;
        end else if (scan_cmd && !hit && rhit) begin
          state_nxt = S_ROW;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_VAL: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_any_r   <= '0;
      row_full_r  <= '0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (do_write) begin
        row_any_r[row_c]  <= |nr;
        row_full_r[row_c] <= &nr;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r      <= in_tuser;
      key_r      <= in_key;
      val_r      <= VALUE_BITS'(in_value);
      in_range_r <= (32'(in_key) < 32'(SLOT_COUNT));
      pos_r      <= (in_tuser == CMD_ALLOC) ? '0 : SW'(32'(in_key));
    end
    case (state_r)
      S_ROW: begin
        if (skip) begin
          res_value_r  <= '0;
          res_index_r  <= IDXO_W'(SLOT_COUNT);
          res_status_r <= 1'b1;
        end
      end
      S_EVAL: begin
        if (scan_cmd) begin
          if (hit_ok) begin
            res_value_r  <= '0;
            res_index_r  <= IDXO_W'(found_pos);
            res_status_r <= 1'b0;
          end else if (!hit && rhit) begin
            pos_r <= {nrow, {MAP_SH{1'b0}}};
          end else begin
            res_value_r  <= '0;
            res_index_r  <= IDXO_W'(SLOT_COUNT);
            res_status_r <= 1'b1;
          end
        end else begin
          res_value_r  <= old_val;
          res_index_r  <= IDXO_W'(key_r);
          res_status_r <= (cmd_r == CMD_GET) ? !was_occ : 1'b0;
        end
      end
      S_VAL: begin
        res_value_r <= vr_data;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_value_r  <= VAL_W'(res_value_r);
      out_index_r  <= res_index_r;
      out_status_r <= res_status_r;
      out_count_r  <= CNTO_W'(cnt_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_status_r, out_index_r, out_value_r};

  `STF_ASSERT_ALWAYS(a_cnt_bound, 32'(cnt_r) <= 32'(SLOT_COUNT), "occupied count exceeds capacity")
  `STF_ASSERT_ALWAYS(a_full_any, (row_full_r & ~row_any_r) == '0, "row full but marked empty")
  `STF_ASSERT_NEXT(a_accept_row, in_fire, state_r == S_ROW, "accepted item did not start a read")
  `STF_ASSERT_NEXT(a_out_load, out_load, out_valid_r, "loaded result not presented")

endmodule

[hdl/slot_table_with_free_slot_finder.sv]
// Channel  Direction  tdata                                  tuser
// in_      slave      key, value                             command
// out_     master     result_value, result_index, status,    none
//                     occupied_count
// Get, store, remove and find-next-empty pass through accept, RAM read, evaluate and output.
// Find-next-occupied adds a value RAM read at the found slot before output.
// A scan that misses in its start row reads one more map row chosen by the row summary flags,
// repeating RAM read and evaluate; a non-alloc key out of range or unknown code skips evaluate.
// Reset clears the row summary flags at once, so there is no clearing pass over the RAMs.
// One finished result waits in the output register while the next item is accepted.
module slot_table_with_free_slot_finder
  import stf_pkg::*;
#(
  parameter int SLOT_COUNT = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // key[9:0], value[41:10], zeros above
  input  logic [CMD_W-1:0]      in_tuser,   // command[2:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // result_value[31:0], result_index[42:32],
                                            // status[43], occupied_count[54:44], zero[55]
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int ROWS  = (SLOT_COUNT + MAP_W - 1) / MAP_W;
  localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic                  vr_en, vw_en, mr_en, mw_en;
  logic [IDX_W-1:0]      vr_addr, vw_addr;
  logic [VALUE_BITS-1:0] vr_data, vw_data;
  logic [RA_W-1:0]       mr_addr, mw_addr;
  logic [MAP_W-1:0]      mr_data, mw_data;

  stf_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (SLOT_COUNT),
    .AW    (IDX_W)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (vw_en),
    .wr_addr (vw_addr),
    .wr_data (vw_data),
    .rd_en   (vr_en),
    .rd_addr (vr_addr),
    .rd_data (vr_data)
  );

  stf_ram #(
    .WIDTH (MAP_W),
    .DEPTH (ROWS),
    .AW    (RA_W)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (mw_en),
    .wr_addr (mw_addr),
    .wr_data (mw_data),
    .rd_en   (mr_en),
    .rd_addr (mr_addr),
    .rd_data (mr_data)
  );

  stf_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W),
    .RA_W       (RA_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .vr_en      (vr_en),
    .vr_addr    (vr_addr),
    .vr_data    (vr_data),
    .vw_en      (vw_en),
    .vw_addr    (vw_addr),
    .vw_data    (vw_data),
    .mr_en      (mr_en),
    .mr_addr    (mr_addr),
    .mr_data    (mr_data),
    .mw_en      (mw_en),
    .mw_addr    (mw_addr),
    .mw_data    (mw_data)
  );

endmodule

[test/slot_table_checker.sv]
`timescale 1ns / 1ps
module slot_table_checker
  import stf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // key[9:0], value[41:10], zeros above
  input  logic [CMD_W-1:0]      in_tuser,   // command[2:0]
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // result_value[31:0], result_index[42:32],
                                            // status[43], occupied_count[54:44], zero[55]
  output int                    mismatches,
  output int                    pending
);

  localparam int SLOTS = 1024;
  localparam logic [IDXO_W-1:0] NO_SLOT = IDXO_W'(SLOTS);
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [IDXO_W-1:0] index;
    logic              status;
    logic [CNTO_W-1:0] count;
  } table_answer_t;

  logic [VAL_W-1:0] slot_data [SLOTS];
  int unsigned used_slots;
  table_answer_t answers_due [$];

  task automatic report_mismatch(string line);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("%0t: %s", $time, line);
    end
  endtask

  function automatic int unsigned first_slot(int unsigned start, bit want_used);
    for (int unsigned i = start; i < SLOTS; i++) begin
      if ((slot_data[i] != '0) == want_used) return i;
    end
    return SLOTS;
  endfunction

  function automatic logic [VAL_W-1:0] write_slot(int unsigned idx, logic [VAL_W-1:0] data);
    logic [VAL_W-1:0] old;
    old = slot_data[idx];
    if (old != '0 && data == '0) begin
      used_slots--;
    end else if (old == '0 && data != '0) begin
      used_slots++;
    end
    slot_data[idx] = data;
    return old;
  endfunction

  function automatic table_answer_t apply_command(cmd_t cmd, logic [KEY_W-1:0] key,
                                                  logic [VAL_W-1:0] data);
    table_answer_t ans;
    int unsigned hit;
    ans.value  = '0;
    ans.index  = NO_SLOT;
    ans.status = 1'b1;
    case (cmd)
      CMD_GET: begin
        ans.value  = slot_data[key];
        ans.index  = IDXO_W'(key);
        ans.status = (slot_data[key] == '0);
      end
      CMD_FIND_OCC: begin
        hit = first_slot(key, 1'b1);
        if (hit < SLOTS) begin
          ans.value  = slot_data[hit];
          ans.index  = IDXO_W'(hit);
          ans.status = 1'b0;
        end
      end
      CMD_FIND_EMPTY: begin
        hit = first_slot(key, 1'b0);
        if (hit < SLOTS) begin
          ans.index  = IDXO_W'(hit);
          ans.status = 1'b0;
        end
      end
      CMD_STORE: begin
        ans.value  = write_slot(key, data);
        ans.index  = IDXO_W'(key);
        ans.status = 1'b0;
      end
      CMD_ALLOC: begin
        hit = first_slot(0, 1'b0);
        if (hit < SLOTS) begin
          void'(write_slot(hit, data));
          ans.index  = IDXO_W'(hit);
          ans.status = 1'b0;
        end
      end
      CMD_REMOVE: begin
        ans.value  = write_slot(key, '0);
        ans.index  = IDXO_W'(key);
        ans.status = 1'b0;
      end
      default: begin
      end
    endcase
    ans.count = CNTO_W'(used_slots);
    return ans;
  endfunction

  always @(posedge clk) begin : watch
    table_answer_t got;
    table_answer_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_data[i] = '0;
      end
      used_slots = 0;
      mismatches = 0;
      answers_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.value  = out_tdata[0 +: VAL_W];
        got.index  = out_tdata[VAL_W +: IDXO_W];
        got.status = out_tdata[VAL_W + IDXO_W];
        got.count  = out_tdata[VAL_W + IDXO_W + 1 +: CNTO_W];
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("result item 0x%0h with none expected", out_tdata));
        end else begin
          want = answers_due.pop_front();
          if (got.value !== want.value) begin
            report_mismatch($sformatf("result_value got 0x%0h, expected 0x%0h",
                                      got.value, want.value));
          end
          if (got.index !== want.index) begin
            report_mismatch($sformatf("result_index got %0d, expected %0d",
                                      got.index, want.index));
          end
          if (got.status !== want.status) begin
            report_mismatch($sformatf("status got %0b, expected %0b",
                                      got.status, want.status));
          end
          if (got.count !== want.count) begin
            report_mismatch($sformatf("occupied_count got %0d, expected %0d",
                                      got.count, want.count));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        answers_due.push_back(apply_command(in_tuser, in_tdata[0 +: KEY_W],
                                            in_tdata[KEY_W +: VAL_W]));
      end
    end
    pending = answers_due.size();
  end

endmodule

[test/slot_table_with_free_slot_finder_tb.sv]
`timescale 1ns / 1ps
module slot_table_with_free_slot_finder_tb;
  import stf_pkg::*;

  localparam cmd_t CMD_UNUSED_LO = 3'd6;
  localparam cmd_t CMD_UNUSED_HI = 3'd7;
  localparam logic [KEY_W-1:0] LAST_KEY = '1;
  localparam logic [VAL_W-1:0] ALL_ONES = '1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // key[9:0], value[41:10], zeros above
  logic [CMD_W-1:0]      in_tuser;   // command[2:0]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // result_value[31:0], result_index[42:32],
                                     // status[43], occupied_count[54:44], zero[55]
  int                    mismatches;
  int                    pending;
  bit                    steady;
  logic [KEY_W-1:0]      recent_key;

  always #5 clk = ~clk;

  slot_table_with_free_slot_finder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  slot_table_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 40) return KEY_W'($urandom);
    if (r < 70) return KEY_W'($urandom_range(63));
    if (r < 85) return KEY_W'($urandom_range(1023, 960));
    return recent_key + KEY_W'($urandom_range(3));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 12) return ALL_ONES;
    return $urandom;
  endfunction

  task automatic send_item(cmd_t cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] data);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= cmd;
    in_tdata   <= {{(IN_DATA_W - KEY_W - VAL_W){1'b0}}, data, key};
    recent_key = key;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random_item();
    int r;
    cmd_t cmd;
    r = $urandom_range(99);
    if (r < 14) cmd = CMD_GET;
    else if (r < 28) cmd = CMD_FIND_OCC;
    else if (r < 38) cmd = CMD_FIND_EMPTY;
    else if (r < 62) cmd = CMD_STORE;
    else if (r < 77) cmd = CMD_ALLOC;
    else if (r < 95) cmd = CMD_REMOVE;
    else if (r < 97) cmd = CMD_UNUSED_LO;
    else cmd = CMD_UNUSED_HI;
    send_item(cmd, pick_key(), pick_value());
  endtask

  initial begin : result_sink
    int gap;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(steady ? 200 : 12, 1)) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] k;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    steady     = 1'b0;
    recent_key = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_GET, 10'd0, '0);
    send_item(CMD_FIND_OCC, 10'd0, '0);
    send_item(CMD_FIND_EMPTY, LAST_KEY, '0);
    send_item(CMD_STORE, 10'd0, ALL_ONES);
    send_item(CMD_STORE, LAST_KEY, 32'd1);
    send_item(CMD_GET, 10'd0, '0);
    send_item(CMD_GET, LAST_KEY, ALL_ONES);
    send_item(CMD_FIND_OCC, 10'd1, '0);
    send_item(CMD_FIND_OCC, LAST_KEY, '0);
    send_item(CMD_FIND_EMPTY, 10'd0, '0);
    send_item(CMD_ALLOC, 10'd700, 32'h1234_5678);
    send_item(CMD_ALLOC, 10'd0, '0);
    send_item(CMD_FIND_EMPTY, 10'd0, '0);
    send_item(CMD_STORE, 10'd0, '0);
    send_item(CMD_STORE, 10'd500, 32'hA5A5_A5A5);
    send_item(CMD_STORE, 10'd500, 32'h5A5A_5A5A);
    send_item(CMD_REMOVE, 10'd500, '0);
    send_item(CMD_REMOVE, 10'd500, ALL_ONES);
    send_item(CMD_UNUSED_LO, 10'd3, 32'h0000_00FF);
    send_item(CMD_UNUSED_HI, LAST_KEY, ALL_ONES);
    send_item(CMD_FIND_OCC, 10'd2, '0);
    send_item(CMD_GET, 10'd1, '0);

    for (int i = 0; i < 250; i++) begin
      steady = (i >= 100 && i < 150);
      send_random_item();
    end
    steady = 1'b0;

    for (int i = 0; i < 1040; i++) begin
      steady = (i < 500);
      send_item(CMD_ALLOC, KEY_W'($urandom), $urandom | 32'h1);
    end
    steady = 1'b0;

    for (int i = 0; i < 60; i++) begin
      k = KEY_W'($urandom);
      case (i % 6)
        0: send_item(CMD_ALLOC, k, $urandom | 32'h1);
        1: send_item(CMD_FIND_EMPTY, k, '0);
        2: send_item(CMD_GET, k, '0);
        3: send_item(CMD_FIND_OCC, k, '0);
        4: send_item(CMD_STORE, k, $urandom | 32'h1);
        default: send_item(CMD_REMOVE, k, '0);
      endcase
    end

    for (int i = 0; i < 150; i++) begin
      send_random_item();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/stf_pkg.sv
hdl/stf_ram.sv
hdl/stf_ctrl.sv
hdl/slot_table_with_free_slot_finder.sv
test/slot_table_checker.sv
test/slot_table_with_free_slot_finder_tb.sv
